// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file of the sliding window max block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/swm_pkg.sv =====
// shared constants and the control type of the sliding window max block
// no dependencies
`default_nettype none

package swm_pkg;

  localparam int unsigned MAX_WINDOW_DEF   = 64;
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;
  localparam int unsigned CFG_WIDTH        = 7;

  typedef struct packed {
    logic valid;
    logic has_result;
  } swm_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/swm_cell.sv =====
// one cell of the sample row: holds a sample of a fixed age and its live flag
// uses swm_pkg for parameter defaults
`default_nettype none

module swm_cell #(
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned WIN_WIDTH    = swm_pkg::CFG_WIDTH,
  parameter int unsigned INDEX        = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           shift_i,
  input  logic                           start_i,
  input  logic        [WIN_WIDTH-1:0]    win_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_value_i,
  input  logic                           prev_alive_i,
  output logic signed [SAMPLE_WIDTH-1:0] value_o,
  output logic                           alive_o
);

  localparam logic IS_HEAD = (INDEX == 0);

  logic signed [SAMPLE_WIDTH-1:0] value_q;
  logic                           alive_q, alive_d;
  logic                           age_ok, smaller;

  always_comb begin
    age_ok  = WIN_WIDTH'(INDEX) < win_i;
    smaller = prev_value_i < sample_i;
    alive_q_next: begin
      alive_d = prev_alive_i & (IS_HEAD | (~start_i & age_ok & ~smaller));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 1'b0;
    end else if (shift_i) begin
      alive_q <= alive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      value_q <= prev_value_i;
    end
  end

  assign value_o = value_q;
  assign alive_o = alive_q;

endmodule

`default_nettype wire

// ===== rtl/core/swm_max_tree.sv =====
// registered max tree over the live cells, one register level per tree level
// uses swm_pkg for the control struct
`default_nettype none

module swm_max_tree #(
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned LEAVES       = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           advance_i,
  input  swm_pkg::swm_ctl_t              ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] leaf_val_i [LEAVES],
  input  logic                           leaf_alive_i [LEAVES],
  output swm_pkg::swm_ctl_t              root_ctl_o,
  output logic signed [SAMPLE_WIDTH-1:0] root_val_o
);

  import swm_pkg::*;

  localparam int unsigned LEVELS = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int unsigned P      = 1 << LEVELS;

  logic signed [SAMPLE_WIDTH-1:0] node_val_q   [1:P-1];
  logic                           node_alive_q [1:P-1];
  logic signed [SAMPLE_WIDTH-1:0] node_val_d   [1:P-1];
  logic                           node_alive_d [1:P-1];
  logic signed [SAMPLE_WIDTH-1:0] kid_val      [2:2*P-1];
  logic                           kid_alive    [2:2*P-1];
  swm_ctl_t                       ctl_q        [LEVELS];

  for (genvar c = 2; c < 2 * P; c++) begin : g_kid
    if (c >= P) begin : g_leaf
      if (c - P < LEAVES) begin : g_used
        assign kid_val[c]   = leaf_val_i[c-P];
        assign kid_alive[c] = leaf_alive_i[c-P];
      end else begin : g_pad
        assign kid_val[c]   = '0;
        assign kid_alive[c] = 1'b0;
      end
    end else begin : g_node
      assign kid_val[c]   = node_val_q[c];
      assign kid_alive[c] = node_alive_q[c];
    end
  end

  always_comb begin
    for (int i = 1; i < P; i++) begin
      node_alive_d[i] = kid_alive[2*i] | kid_alive[2*i+1];
      if (kid_alive[2*i] && (!kid_alive[2*i+1] || kid_val[2*i] >= kid_val[2*i+1])) begin
        node_val_d[i] = kid_val[2*i];
      end else begin
        node_val_d[i] = kid_val[2*i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int i = 1; i < P; i++) begin
        node_val_q[i]   <= node_val_d[i];
        node_alive_q[i] <= node_alive_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (advance_i) begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i < LEVELS; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  assign root_ctl_o = ctl_q[LEVELS-1];
  assign root_val_o = node_val_q[1];

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_maximum_top.sv =====
// Sliding window maximum: takes one signed sample per clock while in_ready_o is
// high and, once the current sequence holds at least window_size samples, returns
// the maximum of the last window_size of them. A row of MAX_WINDOW cells holds
// the recent samples, each with a live flag that a newer larger sample, a start
// request or leaving the window clears; a registered max tree over the row gives
// the oldest live value. A result passes from the cell row through the register
// levels of the max tree into the output register. window_size is to be written
// only while idle; the block does not enforce it. 0 acts as 1 and values above
// MAX_WINDOW act as MAX_WINDOW. No clearing pass after reset.
// uses swm_pkg, swm_cell, swm_max_tree
`default_nettype none

module sliding_window_maximum_top #(
  parameter int unsigned MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [swm_pkg::CFG_WIDTH-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_i,
  input  logic                             start_req_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]   window_max_o
);

  import swm_pkg::*;

  localparam int unsigned SEEN_WIDTH = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WIN_WIDTH  = (SEEN_WIDTH > CFG_WIDTH) ? SEEN_WIDTH : CFG_WIDTH;

  logic [CFG_WIDTH-1:0]           window_size_q;
  logic [WIN_WIDTH-1:0]           win_raw, win_eff;
  logic [SEEN_WIDTH-1:0]          seen_q, seen_d;
  logic                           accept, advance, has_result;
  swm_ctl_t                       cell_ctl_q, cell_ctl_d, root_ctl;
  logic signed [SAMPLE_WIDTH-1:0] root_val;
  logic                           out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] out_val_q;
  logic signed [SAMPLE_WIDTH-1:0] cell_val   [MAX_WINDOW];
  logic                           cell_alive [MAX_WINDOW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= CFG_WIDTH'(1);
    end else if (cfg_we_i) begin
      window_size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    win_raw = WIN_WIDTH'(window_size_q);
    if (win_raw == '0) begin
      win_eff = WIN_WIDTH'(1);
    end else if (win_raw > WIN_WIDTH'(MAX_WINDOW)) begin
      win_eff = WIN_WIDTH'(MAX_WINDOW);
    end else begin
      win_eff = win_raw;
    end
  end

  // sample row
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      swm_cell #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .WIN_WIDTH    (WIN_WIDTH),
        .INDEX        (k)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (accept),
        .start_i      (start_req_i),
        .win_i        (win_eff),
        .sample_i     (sample_i),
        .prev_value_i (sample_i),
        .prev_alive_i (1'b1),
        .value_o      (cell_val[k]),
        .alive_o      (cell_alive[k])
      );
    end else begin : g_body
      swm_cell #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .WIN_WIDTH    (WIN_WIDTH),
        .INDEX        (k)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (accept),
        .start_i      (start_req_i),
        .win_i        (win_eff),
        .sample_i     (sample_i),
        .prev_value_i (cell_val[k-1]),
        .prev_alive_i (cell_alive[k-1]),
        .value_o      (cell_val[k]),
        .alive_o      (cell_alive[k])
      );
    end
  end

  always_comb begin
    if (start_req_i) begin
      seen_d = SEEN_WIDTH'(1);
    end else if (seen_q < SEEN_WIDTH'(MAX_WINDOW)) begin
      seen_d = seen_q + SEEN_WIDTH'(1);
    end else begin
      seen_d = seen_q;
    end
    has_result = WIN_WIDTH'(seen_d) >= win_eff;
  end

  // stall only when a result at the tree root cannot move into a full output
  assign advance    = ~(root_ctl.valid & root_ctl.has_result & out_valid_q & ~out_ready_i);
  assign in_ready_o = advance | ~cell_ctl_q.valid;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    if (accept) begin
      cell_ctl_d.valid      = 1'b1;
      cell_ctl_d.has_result = has_result;
    end else if (advance) begin
      cell_ctl_d = '0;
    end else begin
      cell_ctl_d = cell_ctl_q;
    end
    if (advance && root_ctl.valid && root_ctl.has_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      cell_ctl_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        seen_q <= seen_d;
      end
      cell_ctl_q  <= cell_ctl_d;
      out_valid_q <= out_valid_d;
    end
  end

  swm_max_tree #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .LEAVES       (MAX_WINDOW)
  ) u_tree (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .ctl_i        (cell_ctl_q),
    .leaf_val_i   (cell_val),
    .leaf_alive_i (cell_alive),
    .root_ctl_o   (root_ctl),
    .root_val_o   (root_val)
  );

  always_ff @(posedge clk_i) begin
    if (advance && root_ctl.valid && root_ctl.has_result) begin
      out_val_q <= root_val;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = out_val_q;

endmodule

`default_nettype wire

// ===== rtl/core/swm_checker.sv =====
// port-level checks of the sliding window max block, bound to the top level
// uses assert_macros.svh and sliding_window_maximum_top
`default_nettype none
`include "assert_macros.svh"

module swm_checker #(
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] window_max_o
);

  logic any_beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_beat_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      any_beat_q <= 1'b1;
    end
  end

  // a stalled result beat holds
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(window_max_o), "result beat dropped or changed while stalled")

  // input side backs up only behind a stalled result
  `ASSERT_ALWAYS(a_stall_cause, clk_i, !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled without a stalled result")

  // no result before any sample beat
  `ASSERT_RST(a_no_phantom, clk_i, rst_ni, out_valid_o |-> any_beat_q, "result beat without an earlier sample beat")

endmodule

bind sliding_window_maximum_top swm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .window_max_o (window_max_o)
);

`default_nettype wire
